// ----- rtl/pid_controller_ramp_limited_defines.svh -----
// Assertion macros for the ramp-limited PID controller checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PID_CONTROLLER_RAMP_LIMITED_DEFINES_SVH
`define PID_CONTROLLER_RAMP_LIMITED_DEFINES_SVH

// implication to the next cycle, checked in and out of reset
`define PIDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("pidr assertion failed");

// implication to the next cycle, suspended while in reset
`define PIDR_ASSERT_RUN(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pidr assertion failed");

`endif

// ----- rtl/pidr_pkg.sv -----
// Package for the ramp-limited PID controller: config struct, register
// indexes, sequencer and arithmetic unit state types, constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pidr_pkg;

    typedef struct packed {
        logic [30:0] gain_p;
        logic [30:0] gain_i;
        logic [30:0] gain_d;
        logic [30:0] output_limit;
        logic [30:0] ramp_rate;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_OUTPUT_LIMIT = 3'd3,
        REG_RAMP_RATE    = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P,
        ST_T,
        ST_TI,
        ST_U,
        ST_D,
        ST_SUM,
        ST_S,
        ST_RAMP,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MDU_IDLE,
        MDU_MUL,
        MDU_DIV
    } t_mdu_phase;

    localparam logic [30:0] GAIN_P_RESET = 31'd32768;
    localparam logic [30:0] LIMIT_RESET  = 31'h7FFF_FFFF;
    localparam logic [18:0] US_DEFAULT   = 19'd1000;
    localparam logic [31:0] US_MAX       = 32'd500000;
    localparam logic [31:0] US_PER_S     = 32'd1000000;
    localparam logic [31:0] TWO_US_PER_S = 32'd2000000;

endpackage
`default_nettype wire

// ----- rtl/pidr_regs.sv -----
// APB register file for the ramp-limited PID controller.
// Depends on pidr_pkg (t_cfg, register indexes, reset values).
`timescale 1ns / 1ps
`default_nettype none
module pidr_regs
    import pidr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_GAIN_P:       n_cfg.gain_p       = pwdata[30:0];
                REG_GAIN_I:       n_cfg.gain_i       = pwdata[30:0];
                REG_GAIN_D:       n_cfg.gain_d       = pwdata[30:0];
                REG_OUTPUT_LIMIT: n_cfg.output_limit = pwdata[30:0];
                REG_RAMP_RATE:    n_cfg.ramp_rate    = pwdata[30:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p       <= GAIN_P_RESET;
            r_cfg.gain_i       <= '0;
            r_cfg.gain_d       <= '0;
            r_cfg.output_limit <= LIMIT_RESET;
            r_cfg.ramp_rate    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_GAIN_P:       prdata = {1'b0, r_cfg.gain_p};
            REG_GAIN_I:       prdata = {1'b0, r_cfg.gain_i};
            REG_GAIN_D:       prdata = {1'b0, r_cfg.gain_d};
            REG_OUTPUT_LIMIT: prdata = {1'b0, r_cfg.output_limit};
            REG_RAMP_RATE:    prdata = {1'b0, r_cfg.ramp_rate};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- rtl/pidr_mdu.sv -----
// Shared multiply-divide unit: saturate(round(x * m / den)), sign of x,
// shift-add multiply then restoring divide, one bit a cycle. Depends on pidr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pidr_mdu
    import pidr_pkg::*;
#(
    parameter int W  = 32,
    parameter int XW = 33
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [XW-1:0] i_x,
    input  wire logic        [31:0]   i_m,
    input  wire logic        [31:0]   i_den,
    output logic                      o_done,
    output logic signed      [W-1:0]  o_res
);

    localparam int PW = XW + 33;
    localparam int CW = $clog2(PW + 1);

    t_mdu_phase      r_ph, n_ph;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [PW-1:0]   r_acc, n_acc;
    logic [PW-1:0]   r_a, n_a;
    logic [31:0]     r_b, n_b;
    logic [31:0]     r_den, n_den;
    logic [31:0]     r_rem, n_rem;
    logic [W:0]      r_q, n_q;
    logic            r_ovf, n_ovf;
    logic            r_neg, n_neg;
    logic            r_done, n_done;

    logic [XW-1:0]   mag;
    logic [32:0]     rem_sh;
    logic [32:0]     rem_sub;
    logic            ge;

    assign mag     = i_x[XW-1] ? XW'(-i_x) : XW'(i_x);
    assign rem_sh  = {r_rem, r_acc[PW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = (rem_sh >= {1'b0, r_den});

    always_comb begin
        n_ph   = r_ph;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_den  = r_den;
        n_rem  = r_rem;
        n_q    = r_q;
        n_ovf  = r_ovf;
        n_neg  = r_neg;
        n_done = 1'b0;
        case (r_ph)
            MDU_IDLE: begin
                if (i_start) begin
                    n_acc = PW'(i_den >> 1);
                    n_a   = PW'(mag);
                    n_b   = i_m;
                    n_den = i_den;
                    n_neg = i_x[XW-1];
                    n_cnt = '0;
                    n_ph  = MDU_MUL;
                end
            end
            MDU_MUL: begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a   = r_a << 1;
                n_b   = r_b >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(31)) begin
                    n_ph  = MDU_DIV;
                    n_cnt = '0;
                    n_rem = '0;
                    n_q   = '0;
                    n_ovf = 1'b0;
                end
            end
            MDU_DIV: begin
                n_rem = ge ? rem_sub[31:0] : rem_sh[31:0];
                n_acc = r_acc << 1;
                n_q   = {r_q[W-1:0], ge};
                n_ovf = r_ovf | r_q[W];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(PW - 1)) begin
                    n_ph   = MDU_IDLE;
                    n_done = 1'b1;
                end
            end
            default: n_ph = MDU_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= MDU_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_ovf <= n_ovf;
        r_neg <= n_neg;
    end

    logic big;
    assign big = r_ovf | r_q[W];

    always_comb begin
        if (r_neg) begin
            if (big || (r_q[W-1] && (|r_q[W-2:0]))) begin
                o_res = {1'b1, {(W-1){1'b0}}};
            end else begin
                o_res = W'(-r_q[W-1:0]);
            end
        end else begin
            if (big || r_q[W-1]) begin
                o_res = {1'b0, {(W-1){1'b1}}};
            end else begin
                o_res = W'(r_q[W-1:0]);
            end
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

// ----- rtl/pid_controller_ramp_limited.sv -----
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_ready  | i_error_sample, i_elapsed_us
// result   | out       | o_valid / i_ready  | o_drive_value
// config   | in        | APB psel / penable | paddr, pwdata, prdata
// Each item makes five passes through the shared bit-serial multiply-divide unit,
// or six with ramp limiting on, between acceptance and the return of o_ready.
// o_ready is high only in idle; a result waiting in the output register
// does not block the next item, only the delivery of the one after it.
// Synchronous active-low reset; no clearing pass.
// Depends on pidr_pkg, pidr_regs, pidr_mdu.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_ramp_limited
    import pidr_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_error_sample,
    input  wire logic        [31:0] i_elapsed_us,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed      [31:0] o_drive_value,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [4:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);

    localparam int W   = DATA_WIDTH;
    localparam int XW  = (W + 1 > 20) ? W + 1 : 20;
    localparam int EW  = (W > 32) ? W : 32;
    localparam int LW  = (W > 31) ? W + 1 : 33;
    localparam logic [31:0] ONE = 32'(1 << FRAC_BITS);
    localparam logic signed [EW-1:0]  EMAX = $signed({{(EW - W + 1){1'b0}}, {(W - 1){1'b1}}});
    localparam logic signed [W+1:0]   SMAX = $signed({3'b000, {(W - 1){1'b1}}});
    localparam logic signed [W+1:0]   SMIN = ~SMAX;

    t_cfg cfg;

    pidr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    assign pready = 1'b1;

    function automatic logic signed [W-1:0] f_sat(input logic signed [W+1:0] v);
        logic signed [W-1:0] r;
        if (v > SMAX) begin
            r = SMAX[W-1:0];
        end else if (v < SMIN) begin
            r = SMIN[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] f_clamp(input logic signed [W-1:0] v,
                                                    input logic [30:0] lim);
        logic signed [LW-1:0] l;
        logic signed [LW-1:0] ve;
        logic signed [W-1:0]  r;
        l  = $signed(LW'(lim));
        ve = LW'(v);
        if (ve > l) begin
            r = l[W-1:0];
        end else if (ve < -l) begin
            r = W'(-l);
        end else begin
            r = v;
        end
        return r;
    endfunction

    t_state               r_state, n_state;
    logic                 r_go, n_go;
    logic signed [W-1:0]  r_e, n_e;
    logic        [18:0]   r_us, n_us;
    logic signed [W-1:0]  r_p, n_p;
    logic signed [W-1:0]  r_t, n_t;
    logic signed [W-1:0]  r_integ, n_integ;
    logic signed [W-1:0]  r_u, n_u;
    logic signed [W-1:0]  r_y, n_y;
    logic signed [W-1:0]  r_s, n_s;
    logic signed [W-1:0]  r_ie, n_ie;
    logic signed [W-1:0]  r_lo, n_lo;
    logic signed [W-1:0]  r_le, n_le;
    logic                 r_ovalid, n_ovalid;
    logic signed [31:0]   r_out, n_out;

    logic signed [XW-1:0] mdu_x;
    logic        [31:0]   mdu_m;
    logic        [31:0]   mdu_den;
    logic                 mdu_done;
    logic signed [W-1:0]  mdu_res;

    pidr_mdu #(
        .W  (W),
        .XW (XW)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_x     (mdu_x),
        .i_m     (mdu_m),
        .i_den   (mdu_den),
        .o_done  (mdu_done),
        .o_res   (mdu_res)
    );

    logic signed [EW-1:0] e_ext;
    logic signed [W-1:0]  e_sat;
    logic signed [W+1:0]  sum_y;
    logic signed [W+1:0]  diff;
    logic signed [W+1:0]  s_ext;

    assign e_ext = EW'(i_error_sample);
    assign e_sat = (e_ext > EMAX) ? EMAX[W-1:0] :
                   (e_ext < ~EMAX) ? W'(~EMAX) : e_ext[W-1:0];
    assign sum_y = (W+2)'(r_p) + (W+2)'(r_integ) + (W+2)'(mdu_res);
    assign diff  = (W+2)'(r_y) - (W+2)'(r_lo);
    assign s_ext = (W+2)'(r_s);

    always_comb begin
        mdu_x   = XW'(r_e);
        mdu_m   = {1'b0, cfg.gain_p};
        mdu_den = ONE;
        case (r_state)
            ST_T: begin
                mdu_x = XW'(r_e) + XW'(r_le);
                mdu_m = {1'b0, cfg.gain_i};
            end
            ST_TI: begin
                mdu_x   = XW'(r_t);
                mdu_m   = 32'(r_us);
                mdu_den = TWO_US_PER_S;
            end
            ST_U: begin
                mdu_x = XW'(r_e) - XW'(r_le);
                mdu_m = {1'b0, cfg.gain_d};
            end
            ST_D: begin
                mdu_x   = XW'(r_u);
                mdu_m   = US_PER_S;
                mdu_den = 32'(r_us);
            end
            ST_S: begin
                mdu_x   = $signed(XW'(r_us));
                mdu_m   = {1'b0, cfg.ramp_rate};
                mdu_den = US_PER_S;
            end
            default: mdu_x = XW'(r_e);
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_go     = 1'b0;
        n_e      = r_e;
        n_us     = r_us;
        n_p      = r_p;
        n_t      = r_t;
        n_integ  = r_integ;
        n_u      = r_u;
        n_y      = r_y;
        n_s      = r_s;
        n_ie     = r_ie;
        n_lo     = r_lo;
        n_le     = r_le;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_e  = e_sat;
                    n_us = (i_elapsed_us == '0 || i_elapsed_us > US_MAX) ?
                           US_DEFAULT : i_elapsed_us[18:0];
                    n_go    = 1'b1;
                    n_state = ST_P;
                end
            end
            ST_P: begin
                if (mdu_done) begin
                    n_p     = mdu_res;
                    n_go    = 1'b1;
                    n_state = ST_T;
                end
            end
            ST_T: begin
                if (mdu_done) begin
                    n_t     = mdu_res;
                    n_go    = 1'b1;
                    n_state = ST_TI;
                end
            end
            ST_TI: begin
                if (mdu_done) begin
                    n_integ = f_clamp(f_sat((W+2)'(r_ie) + (W+2)'(mdu_res)),
                                      cfg.output_limit);
                    n_go    = 1'b1;
                    n_state = ST_U;
                end
            end
            ST_U: begin
                if (mdu_done) begin
                    n_u     = mdu_res;
                    n_go    = 1'b1;
                    n_state = ST_D;
                end
            end
            ST_D: begin
                if (mdu_done) begin
                    n_y     = f_clamp(f_sat(sum_y), cfg.output_limit);
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (cfg.ramp_rate != '0) begin
                    n_go    = 1'b1;
                    n_state = ST_S;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_S: begin
                if (mdu_done) begin
                    n_s     = mdu_res;
                    n_state = ST_RAMP;
                end
            end
            ST_RAMP: begin
                if (diff > s_ext) begin
                    n_y = f_sat((W+2)'(r_lo) + s_ext);
                end else if (diff < -s_ext) begin
                    n_y = f_sat((W+2)'(r_lo) - s_ext);
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_out    = 32'(r_y);
                    n_ovalid = 1'b1;
                    n_ie     = r_integ;
                    n_lo     = r_y;
                    n_le     = r_e;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
            r_ie     <= '0;
            r_lo     <= '0;
            r_le     <= '0;
        end else begin
            r_state  <= n_state;
            r_go     <= n_go;
            r_ovalid <= n_ovalid;
            r_ie     <= n_ie;
            r_lo     <= n_lo;
            r_le     <= n_le;
        end
        r_e     <= n_e;
        r_us    <= n_us;
        r_p     <= n_p;
        r_t     <= n_t;
        r_integ <= n_integ;
        r_u     <= n_u;
        r_y     <= n_y;
        r_s     <= n_s;
        r_out   <= n_out;
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_drive_value = r_out;

endmodule
`default_nettype wire

// ----- rtl/pidr_chk.sv -----
// Port-level checker for the ramp-limited PID controller, bound to the top.
// Depends on pid_controller_ramp_limited_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_controller_ramp_limited_defines.svh"
module pidr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_drive_value
);

    // reset leaves nothing to deliver and the input open
    `PIDR_ASSERT_NEXT(a_rst_empty, !i_rst_n, !o_valid && o_ready)
    // an accepted item keeps the block busy for the next cycle
    `PIDR_ASSERT_RUN(a_busy_after_accept, i_valid && o_ready, !o_ready)
    // a result is only raised while busy finishing an item
    `PIDR_ASSERT_RUN(a_result_from_work, !o_valid && o_ready, !o_valid)
    // a stalled result holds
    `PIDR_ASSERT_RUN(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_drive_value))

endmodule

bind pid_controller_ramp_limited pidr_chk u_pidr_chk (.*);
`default_nettype wire
